[src/ptc_pkg.sv]
// Shared types and constants of the pressure/temperature compensation unit.
`timescale 1ns / 1ps
package ptc_pkg;

   // Field widths.
   localparam int RAW_W  = 24;
   localparam int COEF_W = 16;
   localparam int OUT_W  = 32;

   // Internal value widths, sized to the worst-case range of each term.
   localparam int DT_W      = 25;  // D2 - C5*256
   localparam int PROD_W    = 42;  // dT times a 16-bit coefficient
   localparam int DTSQ_W    = 48;  // dT squared
   localparam int DEV_W     = 19;  // T - 2000
   localparam int OFF_W     = 36;  // first-order offset
   localparam int SENS_W    = 35;  // first-order sensitivity
   localparam int SQ_W      = 35;  // (T - 2000)^2 and (T + 1500)^2
   localparam int T2_W      = 17;  // temperature second-order term
   localparam int OFFA_W    = 35;
   localparam int OFFB_W    = 38;
   localparam int SENSA_W   = 34;
   localparam int SENSB_W   = 37;
   localparam int OFFNET_W  = 40;
   localparam int SENSNET_W = 39;
   localparam int SPLIT_W   = 20;  // low slice of the sensitivity for the split multiply
   localparam int PART_W    = 44;
   localparam int WIDE_W    = 64;

   // Temperature reference and band edge (T < -1500 means dev < -3500).
   localparam int T_REF     = 2000;
   localparam int LOW_EDGE  = 3500;

   // Register map.
   localparam int CSR_IDX_W = 3;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENS_COEFF    = 3'd0,
      CSR_OFFSET_COEFF  = 3'd1,
      CSR_SENS_TEMPCO   = 3'd2,
      CSR_OFFSET_TEMPCO = 3'd3,
      CSR_REF_TEMP      = 3'd4,
      CSR_TEMP_SLOPE    = 3'd5
   } ptc_csr_index_type;

   typedef struct packed {
      logic [COEF_W-1:0] sens_coeff;
      logic [COEF_W-1:0] offset_coeff;
      logic [COEF_W-1:0] sens_tempco;
      logic [COEF_W-1:0] offset_tempco;
      logic [COEF_W-1:0] ref_temp;
      logic [COEF_W-1:0] temp_slope;
   } ptc_cal_type;

   typedef struct packed {
      logic [RAW_W-1:0] raw_pressure;
      logic [RAW_W-1:0] raw_temp;
   } ptc_req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] pressure;
      logic signed [OUT_W-1:0] temperature;
   } ptc_rsp_type;

   // Handoff from the first-order front end to the second-order stage.
   typedef struct packed {
      logic                      valid;
      logic [RAW_W-1:0]          d1;
      logic signed [DEV_W-1:0]   dev;
      logic signed [OFF_W-1:0]   off;
      logic signed [SENS_W-1:0]  sens;
      logic [SQ_W-1:0]           devsq;
      logic [SQ_W-1:0]           lowsq;
      logic [T2_W-1:0]           t2;
      logic                      warm;
      logic                      cold;
   } ptc_first_type;

   // Handoff from the second-order stage to the pressure stage.
   typedef struct packed {
      logic                         valid;
      logic [RAW_W-1:0]             d1;
      logic signed [OFFNET_W-1:0]   off_net;
      logic signed [SENSNET_W-1:0]  sens_net;
      logic signed [OUT_W-1:0]      temperature;
   } ptc_second_type;

endpackage

[src/ptc_front.sv]
// First-order compensation: dT, T, OFF, SENS and the squared deviations.
`timescale 1ns / 1ps
module ptc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  ptc_pkg::ptc_req_type in_data,
   input  ptc_pkg::ptc_cal_type cal,
   output ptc_pkg::ptc_first_type out
);
   import ptc_pkg::*;

   // stage 1: dT
   logic                     v1_ff;
   logic [RAW_W-1:0]         d1_s1_ff;
   logic signed [DT_W-1:0]   dt_ff, dt_in;

   // stage 2: products
   logic                       v2_ff;
   logic [RAW_W-1:0]           d1_s2_ff;
   logic signed [PROD_W-1:0]   dtc6_ff, dtc6_in;
   logic signed [PROD_W-1:0]   c4dt_ff, c4dt_in;
   logic signed [PROD_W-1:0]   c3dt_ff, c3dt_in;
   logic [DTSQ_W-1:0]          dtsq_ff, dtsq_in;
   logic signed [2*DT_W-1:0]   dtsq_full;

   // stage 3: T deviation, OFF, SENS
   logic                      v3_ff;
   logic [RAW_W-1:0]          d1_s3_ff;
   logic signed [DEV_W-1:0]   dev_ff, dev_in;
   logic signed [DEV_W-1:0]   lowdev_ff, lowdev_in;
   logic signed [OFF_W-1:0]   off_ff, off_in;
   logic signed [SENS_W-1:0]  sens_ff, sens_in;
   logic [DTSQ_W-1:0]         dtsq_s3_ff;
   logic signed [OFF_W-2:0]   c4sh;
   logic signed [SENS_W-2:0]  c3sh;

   // stage 4: squares and T2
   ptc_first_type             out_ff, out_in;
   logic signed [2*DEV_W-1:0] devsq_full;
   logic signed [2*DEV_W-1:0] lowsq_full;
   logic [DTSQ_W+2:0]         t2_warm_full;
   logic [DTSQ_W+1:0]         t2_cold_full;

   assign dt_in = $signed({1'b0, in_data.raw_temp}) - $signed({1'b0, cal.ref_temp, 8'b0});

   assign dtc6_in   = dt_ff * $signed({1'b0, cal.temp_slope});
   assign c4dt_in   = dt_ff * $signed({1'b0, cal.offset_tempco});
   assign c3dt_in   = dt_ff * $signed({1'b0, cal.sens_tempco});
   assign dtsq_full = dt_ff * dt_ff;
   assign dtsq_in   = dtsq_full[DTSQ_W-1:0];

   // floor shifts of the products are plain arithmetic part-selects
   assign dev_in    = dtc6_ff[PROD_W-1:23];
   assign lowdev_in = dev_in + DEV_W'(LOW_EDGE);
   assign c4sh      = c4dt_ff[PROD_W-1:7];
   assign c3sh      = c3dt_ff[PROD_W-1:8];
   assign off_in    = $signed({4'b0, cal.offset_coeff, 16'b0}) + OFF_W'(c4sh);
   assign sens_in   = $signed({4'b0, cal.sens_coeff, 15'b0}) + SENS_W'(c3sh);

   assign devsq_full   = dev_ff * dev_ff;
   assign lowsq_full   = lowdev_ff * lowdev_ff;
   assign t2_warm_full = (DTSQ_W+3)'({dtsq_s3_ff, 3'b0}) - (DTSQ_W+3)'(dtsq_s3_ff);
   assign t2_cold_full = (DTSQ_W+2)'({dtsq_s3_ff, 1'b0}) + (DTSQ_W+2)'(dtsq_s3_ff);

   always_comb begin
      out_in       = '0;
      out_in.valid = v3_ff;
      out_in.d1    = d1_s3_ff;
      out_in.dev   = dev_ff;
      out_in.off   = off_ff;
      out_in.sens  = sens_ff;
      out_in.devsq = devsq_full[SQ_W-1:0];
      out_in.lowsq = lowsq_full[SQ_W-1:0];
      out_in.warm  = !dev_ff[DEV_W-1];
      out_in.cold  = dev_ff < -DEV_W'(LOW_EDGE);
      if (!dev_ff[DEV_W-1]) begin
         out_in.t2 = T2_W'(t2_warm_full[DTSQ_W+2:37]);
      end else begin
         out_in.t2 = t2_cold_full[DTSQ_W+1:33];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         out_ff <= '0;
      end else begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_s1_ff   <= in_data.raw_pressure;
      dt_ff      <= dt_in;
      d1_s2_ff   <= d1_s1_ff;
      dtc6_ff    <= dtc6_in;
      c4dt_ff    <= c4dt_in;
      c3dt_ff    <= c3dt_in;
      dtsq_ff    <= dtsq_in;
      d1_s3_ff   <= d1_s2_ff;
      dev_ff     <= dev_in;
      lowdev_ff  <= lowdev_in;
      off_ff     <= off_in;
      sens_ff    <= sens_in;
      dtsq_s3_ff <= dtsq_ff;
   end

   assign out = out_ff;

endmodule

[src/ptc_second.sv]
// Second-order band corrections and net offset/sensitivity.
`timescale 1ns / 1ps
module ptc_second (
   input  logic                   clock,
   input  logic                   reset,
   input  ptc_pkg::ptc_first_type in,
   output ptc_pkg::ptc_second_type out
);
   import ptc_pkg::*;

   // stage 5: correction terms and final temperature
   logic                      v5_ff;
   logic [RAW_W-1:0]          d1_ff;
   logic signed [OFF_W-1:0]   off_ff;
   logic signed [SENS_W-1:0]  sens_ff;
   logic signed [OUT_W-1:0]   temp_ff, temp_in;
   logic [OFFA_W-1:0]         offa_ff, offa_in;
   logic [OFFB_W-1:0]         offb_ff, offb_in;
   logic [SENSA_W-1:0]        sensa_ff, sensa_in;
   logic [SENSB_W-1:0]        sensb_ff, sensb_in;
   logic signed [DEV_W+1:0]   tsum;
   logic [SQ_W+1:0]           devsq3;
   logic [SQ_W+1:0]           devsq5;

   // stage 6
   ptc_second_type            out_ff, out_in;

   assign tsum   = (DEV_W+2)'(in.dev) + (DEV_W+2)'(T_REF) - $signed((DEV_W+2)'(in.t2));
   assign temp_in = OUT_W'(tsum);
   assign devsq3 = (SQ_W+2)'({in.devsq, 1'b0}) + (SQ_W+2)'(in.devsq);
   assign devsq5 = (SQ_W+2)'({in.devsq, 2'b0}) + (SQ_W+2)'(in.devsq);

   always_comb begin
      if (in.warm) begin
         offa_in  = OFFA_W'(in.devsq[SQ_W-1:4]);
         sensa_in = '0;
      end else begin
         offa_in  = devsq3[SQ_W+1:2];
         sensa_in = devsq5[SQ_W+1:3];
      end
      if (in.cold) begin
         offb_in  = OFFB_W'({in.lowsq, 3'b0}) - OFFB_W'(in.lowsq);
         sensb_in = {in.lowsq, 2'b0};
      end else begin
         offb_in  = '0;
         sensb_in = '0;
      end
   end

   always_comb begin
      out_in             = '0;
      out_in.valid       = v5_ff;
      out_in.d1          = d1_ff;
      out_in.temperature = temp_ff;
      out_in.off_net     = OFFNET_W'(off_ff) - $signed(OFFNET_W'(offa_ff))
                           - $signed(OFFNET_W'(offb_ff));
      out_in.sens_net    = SENSNET_W'(sens_ff) - $signed(SENSNET_W'(sensa_ff))
                           - $signed(SENSNET_W'(sensb_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff  <= 1'b0;
         out_ff <= '0;
      end else begin
         v5_ff  <= in.valid;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff    <= in.d1;
      off_ff   <= in.off;
      sens_ff  <= in.sens;
      temp_ff  <= temp_in;
      offa_ff  <= offa_in;
      offb_ff  <= offb_in;
      sensa_ff <= sensa_in;
      sensb_ff <= sensb_in;
   end

   assign out = out_ff;

endmodule

[src/ptc_press.sv]
// Pressure: split D1 x SENS multiply, offset subtract and final scaling.
`timescale 1ns / 1ps
module ptc_press (
   input  logic                    clock,
   input  logic                    reset,
   input  ptc_pkg::ptc_second_type in,
   output logic                    out_valid,
   output ptc_pkg::ptc_rsp_type    out_data
);
   import ptc_pkg::*;

   // stage 7: partial products
   logic                         v7_ff;
   logic signed [OFFNET_W-1:0]   off7_ff;
   logic signed [OUT_W-1:0]      temp7_ff;
   logic [PART_W-1:0]            plo_ff, plo_in;
   logic signed [PART_W-1:0]     phi_ff, phi_in;

   // stage 8: full product
   logic                         v8_ff;
   logic signed [OFFNET_W-1:0]   off8_ff;
   logic signed [OUT_W-1:0]      temp8_ff;
   logic signed [WIDE_W-1:0]     prod_ff, prod_in;

   // stage 9: result
   logic                         v9_ff;
   ptc_rsp_type                  rsp_ff, rsp_in;
   logic signed [WIDE_W-22:0]    prod_sh;
   logic signed [WIDE_W-21:0]    diff;

   assign plo_in = PART_W'(in.d1) * PART_W'(in.sens_net[SPLIT_W-1:0]);
   assign phi_in = $signed({1'b0, in.d1}) * $signed(in.sens_net[SENSNET_W-1:SPLIT_W]);

   assign prod_in = $signed({phi_ff, SPLIT_W'(0)}) + $signed(WIDE_W'(plo_ff));

   // the ranges of D1, OFF and SENS keep both results inside 32 bits
   assign prod_sh = prod_ff[WIDE_W-1:21];
   assign diff    = (WIDE_W-20)'(prod_sh) - (WIDE_W-20)'(off8_ff);

   always_comb begin
      rsp_in.pressure    = OUT_W'($signed(diff[WIDE_W-21:15]));
      rsp_in.temperature = temp8_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else begin
         v7_ff <= in.valid;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      off7_ff  <= in.off_net;
      temp7_ff <= in.temperature;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      off8_ff  <= off7_ff;
      temp8_ff <= temp7_ff;
      prod_ff  <= prod_in;
      rsp_ff   <= rsp_in;
   end

   assign out_valid = v9_ff;
   assign out_data  = rsp_ff;

endmodule

[src/pressure_temp_compensation_unit.sv]
// Top level of the pressure/temperature compensation unit.
`timescale 1ns / 1ps
// 9 register stages lie between start and the rsp_valid strobe.
// Throughput: one beat per cycle; busy stays low, every start is taken.
// Reset clears the calibration registers and all stage valid bits.
// The receiver cannot stall; each result shows for exactly one cycle.
// Calibration writes are taken at once (csr_ready is always high).
module pressure_temp_compensation_unit (
   input  logic                               clock,
   input  logic                               reset,
   // request beats
   input  logic                               start,
   output logic                               busy,
   input  ptc_pkg::ptc_req_type               req_data,
   // result beats
   output logic                               rsp_valid,
   output ptc_pkg::ptc_rsp_type               rsp_data,
   // calibration write port
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [ptc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptc_pkg::COEF_W-1:0]         csr_data
);
   import ptc_pkg::*;

   ptc_cal_type    cal_ff, cal_in;
   ptc_first_type  first;
   ptc_second_type second;

   // Fully pipelined, nothing to hold off.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Calibration words: decode the index; indexes past the map drop the write.
   always_comb begin
      cal_in = cal_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SENS_COEFF:    cal_in.sens_coeff    = csr_data;
            CSR_OFFSET_COEFF:  cal_in.offset_coeff  = csr_data;
            CSR_SENS_TEMPCO:   cal_in.sens_tempco   = csr_data;
            CSR_OFFSET_TEMPCO: cal_in.offset_tempco = csr_data;
            CSR_REF_TEMP:      cal_in.ref_temp      = csr_data;
            CSR_TEMP_SLOPE:    cal_in.temp_slope    = csr_data;
            default:           cal_in = cal_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else begin
         cal_ff <= cal_in;
      end
   end

   // Stages 1-4: dT, first-order T/OFF/SENS, squared deviations and T2.
   ptc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (start),
      .in_data  (req_data),
      .cal      (cal_ff),
      .out      (first)
   );

   // Stages 5-6: band corrections, final temperature, net OFF and SENS.
   ptc_second u_second (
      .clock (clock),
      .reset (reset),
      .in    (first),
      .out   (second)
   );

   // Stages 7-9: split multiply, offset subtract, scale to the result register.
   ptc_press u_press (
      .clock     (clock),
      .reset     (reset),
      .in        (second),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

endmodule
